### rtl/eurf_pkg.sv
// ----------------------------------------------------------------------------
// eurf_pkg
// Shared types and constants of the Ethernet IPv4/UDP receive filter.
// ----------------------------------------------------------------------------
package eurf_pkg;

    localparam int unsigned LEN_W     = 11;
    localparam int unsigned MAC_W     = 48;
    localparam int unsigned PORT_W    = 16;
    localparam int unsigned VERDICT_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned MAX_FRAME_DEFAULT  = 1500;
    localparam int unsigned FIFO_DEPTH_DEFAULT = 2;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // byte offsets within the frame
    localparam logic [LEN_W-1:0] MAC_FIRST = LEN_W'(6);
    localparam logic [LEN_W-1:0] MAC_LAST  = LEN_W'(11);
    localparam logic [LEN_W-1:0] ETYPE_HI  = LEN_W'(12);
    localparam logic [LEN_W-1:0] ETYPE_LO  = LEN_W'(13);
    localparam logic [LEN_W-1:0] IHL_POS   = LEN_W'(14);
    localparam logic [LEN_W-1:0] PROTO_POS = LEN_W'(23);
    localparam logic [LEN_W-1:0] PORT_BASE = LEN_W'(16);

    // shortest lengths that hold each checked field
    localparam logic [LEN_W-1:0] MIN_ETH_LEN   = LEN_W'(14);
    localparam logic [LEN_W-1:0] MIN_PROTO_LEN = LEN_W'(24);
    localparam logic [LEN_W-1:0] MIN_PORT_LEN  = LEN_W'(18);

    localparam logic [MAC_W-1:0]  OWN_MAC_RESET     = '0;
    localparam logic [PORT_W-1:0] SERVER_PORT_RESET = PORT_W'(1111);
    localparam logic [PORT_W-1:0] CLIENT_PORT_RESET = PORT_W'(2222);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_MAC     = 2'd0,
        CFG_SERVER_PORT = 2'd1,
        CFG_CLIENT_PORT = 2'd2
    } cfg_index_t;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ACCEPT    = 3'd0,
        VERDICT_NOT_IPV4  = 3'd1,
        VERDICT_OWN_FRAME = 3'd2,
        VERDICT_NOT_UDP   = 3'd3,
        VERDICT_PORT_MISS = 3'd4,
        VERDICT_TRUNCATED = 3'd5
    } verdict_t;

    // summary of one frame, handed from the parser to the judge
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [3:0]        ihl;
        logic              is_ipv4;
        logic              is_udp;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } frame_rec_t;

    typedef struct packed {
        logic [MAC_W-1:0]  own_mac;
        logic [PORT_W-1:0] server_port;
        logic [PORT_W-1:0] client_port;
    } filter_cfg_t;

endpackage

### rtl/eurf_parser.sv
// ----------------------------------------------------------------------------
// eurf_parser
// Takes frame bytes, captures the header fields and emits a frame summary
// on the last byte.
// ----------------------------------------------------------------------------
module eurf_parser #(
    parameter int unsigned MAX_FRAME = eurf_pkg::MAX_FRAME_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_frame_byte,
    input  logic                 s_last_byte,
    output logic                 rec_valid,
    input  logic                 rec_ready,
    output eurf_pkg::frame_rec_t rec_data
);
    import eurf_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);

    logic [LEN_W-1:0]  cnt_reg,   cnt_next;
    logic [MAC_W-1:0]  mac_reg,   mac_next;
    logic [15:0]       etype_reg, etype_next;
    logic [3:0]        ihl_reg,   ihl_next;
    logic [7:0]        proto_reg, proto_next;
    logic [PORT_W-1:0] port_reg,  port_next;

    logic             take;
    logic             accept;
    logic [LEN_W-1:0] port_pos;

    assign s_ready   = rec_ready;
    assign accept    = s_valid && s_ready;
    assign rec_valid = s_valid && s_last_byte;

    always_comb begin
        take       = cnt_reg < MAX_LEN;
        port_pos   = PORT_BASE + LEN_W'({ihl_reg, 2'b00});
        cnt_next   = cnt_reg;
        mac_next   = mac_reg;
        etype_next = etype_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        port_next  = port_reg;
        if (take) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg >= MAC_FIRST && cnt_reg <= MAC_LAST) begin
                mac_next = {mac_reg[MAC_W-9:0], s_frame_byte};
            end else if (cnt_reg == ETYPE_HI || cnt_reg == ETYPE_LO) begin
                etype_next = {etype_reg[7:0], s_frame_byte};
            end
            if (cnt_reg == IHL_POS) begin
                ihl_next = s_frame_byte[3:0];
            end
            if (cnt_reg == PROTO_POS) begin
                proto_next = s_frame_byte;
            end
            // port position follows the header length seen so far
            if (cnt_reg > IHL_POS && (cnt_reg == port_pos || cnt_reg == port_pos + 1'b1)) begin
                port_next = {port_reg[7:0], s_frame_byte};
            end
        end
    end

    always_comb begin
        rec_data.len     = cnt_next;
        rec_data.ihl     = ihl_next;
        rec_data.is_ipv4 = etype_next == ETHERTYPE_IPV4;
        rec_data.is_udp  = proto_next == PROTO_UDP;
        rec_data.mac     = mac_next;
        rec_data.port    = port_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            mac_reg   <= '0;
            etype_reg <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            port_reg  <= '0;
        end else if (accept) begin
            if (s_last_byte) begin
                cnt_reg   <= '0;
                mac_reg   <= '0;
                etype_reg <= '0;
                ihl_reg   <= '0;
                proto_reg <= '0;
                port_reg  <= '0;
            end else begin
                cnt_reg   <= cnt_next;
                mac_reg   <= mac_next;
                etype_reg <= etype_next;
                ihl_reg   <= ihl_next;
                proto_reg <= proto_next;
                port_reg  <= port_next;
            end
        end
    end

    a_cnt_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MAX_LEN)
        else $error("byte count beyond frame cap");

    a_cnt_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_byte) |=> cnt_reg == '0)
        else $error("byte count not cleared after last byte");

endmodule

### rtl/eurf_fifo.sv
// ----------------------------------------------------------------------------
// eurf_fifo
// Short register queue between the parser and the judge.
// ----------------------------------------------------------------------------
module eurf_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = eurf_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill beyond depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill not tracking push");

endmodule

### rtl/eurf_judge.sv
// ----------------------------------------------------------------------------
// eurf_judge
// Turns a frame summary into a verdict and holds it in the output register.
// ----------------------------------------------------------------------------
module eurf_judge (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  eurf_pkg::filter_cfg_t                cfg,
    input  logic                                 rec_valid,
    output logic                                 rec_ready,
    input  eurf_pkg::frame_rec_t                 rec_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output eurf_pkg::verdict_t                   m_verdict,
    output logic [eurf_pkg::MAC_W-1:0]           m_sender_mac,
    output logic [eurf_pkg::LEN_W-1:0]           m_frame_length
);
    import eurf_pkg::*;

    logic             m_valid_reg;
    verdict_t         verdict_reg, verdict_next;
    logic [MAC_W-1:0] mac_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] port_len;
    logic             port_hit;

    assign rec_ready      = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_verdict      = verdict_reg;
    assign m_sender_mac   = mac_reg;
    assign m_frame_length = len_reg;

    always_comb begin
        port_len = MIN_PORT_LEN + LEN_W'({rec_data.ihl, 2'b00});
        port_hit = rec_data.port == cfg.server_port || rec_data.port == cfg.client_port;
        priority if (rec_data.len < MIN_ETH_LEN) begin
            verdict_next = VERDICT_TRUNCATED;
        end else if (!rec_data.is_ipv4) begin
            verdict_next = VERDICT_NOT_IPV4;
        end else if (rec_data.mac == cfg.own_mac) begin
            verdict_next = VERDICT_OWN_FRAME;
        end else if (rec_data.len < MIN_PROTO_LEN) begin
            verdict_next = VERDICT_TRUNCATED;
        end else if (!rec_data.is_udp) begin
            verdict_next = VERDICT_NOT_UDP;
        end else if (rec_data.len < port_len) begin
            verdict_next = VERDICT_TRUNCATED;
        end else if (!port_hit) begin
            verdict_next = VERDICT_PORT_MISS;
        end else begin
            verdict_next = VERDICT_ACCEPT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rec_valid && rec_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_valid && rec_ready) begin
            verdict_reg <= verdict_next;
            mac_reg     <= rec_data.mac;
            len_reg     <= rec_data.len;
        end
    end

    a_accept_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && verdict_reg == VERDICT_ACCEPT) |-> len_reg >= MIN_PORT_LEN)
        else $error("accepted frame too short to hold the port");

endmodule

### rtl/eth_ipv4_udp_rx_filter_top.sv
// ----------------------------------------------------------------------------
// eth_ipv4_udp_rx_filter_top
// Ethernet IPv4/UDP receive filter: one verdict per received frame.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one frame byte per transaction, s_last_byte on the final byte.
//   Bytes are taken every cycle; s_ready only drops while the frame queue is
//   full, which happens only when m_ready has been held low.
//   m_ channel: one transaction per frame with verdict, source mac and the
//   frame length (capped at MAX_FRAME; later bytes are counted nowhere).
//   Path: the last byte's record goes from the parser into the queue, then
//   into the judge's output register, which drives m_.
//   Throughput: one byte per cycle sustained, up to one verdict per cycle.
//   cfg_ channel: index 0 own mac, 1 server port, 2 client port, other
//   indexes ignored; always ready, write only while no frame is in flight.
//   Reset: config returns to own mac 0, ports 1111 and 2222, any partial
//   frame and queued verdicts are dropped.
//   A stalled m_ready holds the verdict; up to FIFO_DEPTH further frames are
//   queued behind it before s_ready falls.
// ----------------------------------------------------------------------------
module eth_ipv4_udp_rx_filter_top #(
    parameter int unsigned MAX_FRAME  = eurf_pkg::MAX_FRAME_DEFAULT,
    parameter int unsigned FIFO_DEPTH = eurf_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_frame_byte,
    input  logic                               s_last_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [eurf_pkg::VERDICT_W-1:0]     m_verdict,
    output logic [eurf_pkg::MAC_W-1:0]         m_sender_mac,
    output logic [eurf_pkg::LEN_W-1:0]         m_frame_length,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [eurf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [eurf_pkg::MAC_W-1:0]         cfg_data
);
    import eurf_pkg::*;

    filter_cfg_t cfg_reg;
    logic        pr_valid, pr_ready;
    frame_rec_t  pr_data;
    logic        qj_valid, qj_ready;
    frame_rec_t  qj_data;
    verdict_t    verdict;

    assign cfg_ready = 1'b1;
    assign m_verdict = verdict;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_mac     <= OWN_MAC_RESET;
            cfg_reg.server_port <= SERVER_PORT_RESET;
            cfg_reg.client_port <= CLIENT_PORT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_OWN_MAC:     cfg_reg.own_mac     <= cfg_data;
                CFG_SERVER_PORT: cfg_reg.server_port <= cfg_data[PORT_W-1:0];
                CFG_CLIENT_PORT: cfg_reg.client_port <= cfg_data[PORT_W-1:0];
                default: ;
            endcase
        end
    end

    eurf_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_frame_byte (s_frame_byte),
        .s_last_byte  (s_last_byte),
        .rec_valid    (pr_valid),
        .rec_ready    (pr_ready),
        .rec_data     (pr_data)
    );

    eurf_fifo #(
        .WIDTH ($bits(frame_rec_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (pr_valid),
        .push_ready (pr_ready),
        .push_data  (pr_data),
        .pop_valid  (qj_valid),
        .pop_ready  (qj_ready),
        .pop_data   (qj_data)
    );

    eurf_judge u_judge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .rec_valid      (qj_valid),
        .rec_ready      (qj_ready),
        .rec_data       (qj_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (verdict),
        .m_sender_mac   (m_sender_mac),
        .m_frame_length (m_frame_length)
    );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Ethernet IPv4/UDP receive filter. Frames are
// streamed in byte by byte with random gaps and output back-pressure. Each
// accepted byte goes through a local model of the filter, and every verdict
// is compared field by field with the oldest verdict still due. Directed
// frames come first, then random phases under several port and mac settings.
// ----------------------------------------------------------------------------
module testbench;
    import eurf_pkg::*;

    localparam int MAX_FRAME    = MAX_FRAME_DEFAULT;
    localparam int RANDOM_BYTES = 200;
    localparam int MIN_VERDICTS = 12;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        verdict_t          verdict;
        logic [MAC_W-1:0]  mac;
        logic [LEN_W-1:0]  length;
    } verdict_rec_t;

    typedef struct packed {
        logic [11:0]       len;
        logic [MAC_W-1:0]  mac;
        logic [15:0]       etype;
        logic [7:0]        ihl_byte;
        logic [7:0]        proto;
        logic [15:0]       port;
        logic              typed;
        verdict_t          verdict;
    } frame_row_t;

    localparam logic [MAC_W-1:0] HOST_MAC = 48'h02_00_5e_10_00_01;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_frame_byte;
    logic                  s_last_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [VERDICT_W-1:0]  m_verdict;
    logic [MAC_W-1:0]      m_sender_mac;
    logic [LEN_W-1:0]      m_frame_length;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [MAC_W-1:0]      cfg_data;

    eth_ipv4_udp_rx_filter_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_byte   (s_frame_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_sender_mac   (m_sender_mac),
        .m_frame_length (m_frame_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // filter model: configuration and per-frame capture
    logic [MAC_W-1:0]  own_mac_q     = OWN_MAC_RESET;
    logic [PORT_W-1:0] server_port_q = SERVER_PORT_RESET;
    logic [PORT_W-1:0] client_port_q = CLIENT_PORT_RESET;
    logic [LEN_W-1:0]  rx_count = '0;
    logic [MAC_W-1:0]  rx_mac   = '0;
    logic [15:0]       rx_etype = '0;
    logic [3:0]        rx_ihl   = '0;
    logic [7:0]        rx_proto = '0;
    logic [15:0]       rx_port  = '0;

    verdict_rec_t verdicts_due[$];
    logic [7:0]   frame_bytes[$];

    int mismatches   = 0;
    int verdicts_got = 0;
    int bytes_sent   = 0;
    int idle_cycles  = 0;
    int hold_req     = 0;
    int hold_left    = 0;
    bit quiet        = 1'b0;

    // typed-in expectation travelling with the last byte of a directed frame
    bit           pin_now = 1'b0;
    verdict_rec_t pin_rec;
    verdict_rec_t no_pin = '{VERDICT_ACCEPT, '0, '0};

    frame_row_t frame_plan [14] = '{
        '{12'd38,   HOST_MAC, 16'h0800, 8'h45, 8'd17, 16'd1111, 1'b1, VERDICT_ACCEPT},
        '{12'd38,   HOST_MAC, 16'h0800, 8'h45, 8'd17, 16'd2222, 1'b1, VERDICT_ACCEPT},
        '{12'd38,   HOST_MAC, 16'h0800, 8'h45, 8'd17, 16'h0000, 1'b1, VERDICT_PORT_MISS},
        '{12'd38,   HOST_MAC, 16'h0800, 8'h45, 8'd17, 16'hffff, 1'b1, VERDICT_PORT_MISS},
        '{12'd20,   HOST_MAC, 16'h86dd, 8'h45, 8'd17, 16'd1111, 1'b1, VERDICT_NOT_IPV4},
        '{12'd14,   48'hffff_ffff_ffff, 16'hffff, 8'hff, 8'hff, 16'hffff, 1'b1,
          VERDICT_NOT_IPV4},
        '{12'd14,   48'h0, 16'h0800, 8'h45, 8'd17, 16'd1111, 1'b1, VERDICT_OWN_FRAME},
        '{12'd24,   HOST_MAC, 16'h0800, 8'h45, 8'd6,  16'd1111, 1'b1, VERDICT_NOT_UDP},
        '{12'd1,    HOST_MAC, 16'h0800, 8'h45, 8'd17, 16'd1111, 1'b0, VERDICT_ACCEPT},
        '{12'd13,   HOST_MAC, 16'h0800, 8'h45, 8'd17, 16'd1111, 1'b0, VERDICT_ACCEPT},
        '{12'd14,   HOST_MAC, 16'h0800, 8'h45, 8'd17, 16'd1111, 1'b1, VERDICT_TRUNCATED},
        '{12'd23,   HOST_MAC, 16'h0800, 8'h45, 8'd17, 16'd1111, 1'b1, VERDICT_TRUNCATED},
        '{12'd37,   HOST_MAC, 16'h0800, 8'h45, 8'd17, 16'd1111, 1'b1, VERDICT_TRUNCATED},
        '{12'd24,   HOST_MAC, 16'h0800, 8'h40, 8'd17, 16'd1111, 1'b0, VERDICT_ACCEPT}
    };

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_frame_byte = '0;
        s_last_byte  = 1'b0;
        m_ready      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    // one byte through the filter model; gives a verdict on the last byte
    task automatic filter_step(input logic [7:0] b, input logic last,
                               output bit produced, output verdict_rec_t res);
        int port_at;
        port_at  = 16 + 4 * int'(rx_ihl);
        produced = 1'b0;
        res      = no_pin;
        if (int'(rx_count) < MAX_FRAME) begin
            if (rx_count >= MAC_FIRST && rx_count <= MAC_LAST)
                rx_mac = {rx_mac[MAC_W-9:0], b};
            else if (rx_count == ETYPE_HI || rx_count == ETYPE_LO)
                rx_etype = {rx_etype[7:0], b};
            if (rx_count == IHL_POS)
                rx_ihl = b[3:0];
            if (rx_count == PROTO_POS)
                rx_proto = b;
            if (rx_count > IHL_POS &&
                (int'(rx_count) == port_at || int'(rx_count) == port_at + 1))
                rx_port = {rx_port[7:0], b};
            rx_count = rx_count + 1'b1;
        end
        if (last) begin
            produced   = 1'b1;
            res.mac    = rx_mac;
            res.length = rx_count;
            if (rx_count < MIN_ETH_LEN)
                res.verdict = VERDICT_TRUNCATED;
            else if (rx_etype != ETHERTYPE_IPV4)
                res.verdict = VERDICT_NOT_IPV4;
            else if (rx_mac == own_mac_q)
                res.verdict = VERDICT_OWN_FRAME;
            else if (rx_count < MIN_PROTO_LEN)
                res.verdict = VERDICT_TRUNCATED;
            else if (rx_proto != PROTO_UDP)
                res.verdict = VERDICT_NOT_UDP;
            else if (int'(rx_count) < int'(MIN_PORT_LEN) + 4 * int'(rx_ihl))
                res.verdict = VERDICT_TRUNCATED;
            else if (rx_port != server_port_q && rx_port != client_port_q)
                res.verdict = VERDICT_PORT_MISS;
            else
                res.verdict = VERDICT_ACCEPT;
            rx_count = '0;
            rx_mac   = '0;
            rx_etype = '0;
            rx_ihl   = '0;
            rx_proto = '0;
            rx_port  = '0;
        end
    endtask

    // model update and output checking, all on the rising edge
    always @(posedge aclk) begin
        bit           produced;
        verdict_rec_t res;
        verdict_rec_t want;
        if (!aresetn) begin
            own_mac_q     = OWN_MAC_RESET;
            server_port_q = SERVER_PORT_RESET;
            client_port_q = CLIENT_PORT_RESET;
            rx_count      = '0;
            rx_mac        = '0;
            rx_etype      = '0;
            rx_ihl        = '0;
            rx_proto      = '0;
            rx_port       = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_OWN_MAC:     own_mac_q     = cfg_data;
                    CFG_SERVER_PORT: server_port_q = cfg_data[PORT_W-1:0];
                    CFG_CLIENT_PORT: client_port_q = cfg_data[PORT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                verdicts_got++;
                if (verdicts_due.size() == 0) begin
                    report_mismatch("unexpected verdict", 64'(m_verdict), 64'(0));
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_verdict != want.verdict)
                        report_mismatch("verdict", 64'(m_verdict), 64'(want.verdict));
                    if (m_sender_mac != want.mac)
                        report_mismatch("sender_mac", 64'(m_sender_mac), 64'(want.mac));
                    if (m_frame_length != want.length)
                        report_mismatch("frame_length", 64'(m_frame_length),
                                        64'(want.length));
                end
            end
            if (s_valid && s_ready) begin
                filter_step(s_frame_byte, s_last_byte, produced, res);
                if (produced)
                    verdicts_due.push_back(pin_now ? pin_rec : res);
            end
        end
    end

    // receiver: random stalls, one long hold-off on request, none when quiet
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_req != 0) begin
            m_ready   <= 1'b0;
            hold_req  = 0;
            hold_left = HOLD_CYCLES;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic drive_byte(input logic [7:0] b, input logic last, input bit pin,
                              input verdict_rec_t rec);
        @(negedge aclk);
        // random gaps, each drawn with a 14 percent chance; several may follow one another
        while (!quiet && $urandom_range(0, 99) < 14) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_frame_byte <= b;
        s_last_byte  <= last;
        pin_now = pin;
        pin_rec = rec;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic compose_frame(input int len, input logic [MAC_W-1:0] mac,
                                 input logic [15:0] etype, input logic [7:0] ihl_byte,
                                 input logic [7:0] proto, input logic [15:0] port);
        int port_at;
        frame_bytes.delete();
        for (int i = 0; i < len; i++)
            frame_bytes.push_back(8'($urandom));
        for (int k = 0; k < 6; k++)
            if (6 + k < len)
                frame_bytes[6 + k] = mac[MAC_W-1-8*k -: 8];
        if (len > 12) frame_bytes[12] = etype[15:8];
        if (len > 13) frame_bytes[13] = etype[7:0];
        if (len > 14) frame_bytes[14] = ihl_byte;
        if (len > 23) frame_bytes[23] = proto;
        port_at = 16 + 4 * int'(ihl_byte[3:0]);
        if (len > port_at)     frame_bytes[port_at]     = port[15:8];
        if (len > port_at + 1) frame_bytes[port_at + 1] = port[7:0];
    endtask

    task automatic send_frame(input bit pin, input verdict_rec_t rec);
        int n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++)
            drive_byte(frame_bytes[i], i == n - 1, pin && (i == n - 1), rec);
    endtask

    // mostly well-formed frames with random content, some cut short, some noise
    task automatic make_random_frame();
        int               kind;
        int               need;
        int               len;
        logic [63:0]      wide;
        logic [MAC_W-1:0] mac;
        logic [15:0]      etype;
        logic [15:0]      port;
        logic [7:0]       ihl_byte;
        logic [7:0]       proto;
        kind     = $urandom_range(0, 99);
        wide     = {$urandom, $urandom};
        mac      = ($urandom_range(0, 9) == 0) ? own_mac_q : wide[MAC_W-1:0];
        etype    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETHERTYPE_IPV4;
        ihl_byte = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h45;
        proto    = ($urandom_range(0, 9) == 0) ? 8'($urandom) : PROTO_UDP;
        case ($urandom_range(0, 4))
            0, 1:    port = server_port_q;
            2, 3:    port = client_port_q;
            default: port = 16'($urandom);
        endcase
        need = int'(MIN_PORT_LEN) + 4 * int'(ihl_byte[3:0]);
        if (kind < 70)
            len = need + $urandom_range(0, 10);
        else if (kind < 85)
            len = $urandom_range(1, need);
        else
            len = $urandom_range(1, 40);
        compose_frame(len, mac, etype, ihl_byte, proto, port);
        if (kind >= 85)
            for (int i = 0; i < len; i++)
                frame_bytes[i] = 8'($urandom);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic drain_verdicts();
        release_input();
        while (verdicts_due.size() != 0) @(posedge aclk);
        // verdict pipeline is two deep, let it settle before touching registers
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        verdict_rec_t     rec;
        logic [63:0]      wide;
        logic [MAC_W-1:0] mac_set;
        logic [15:0]      srv_set;
        logic [15:0]      cli_set;
        int               random_base;
        int               verdict_base;
        int               phase;
        bit               more;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed frames under reset configuration
        foreach (frame_plan[r]) begin
            compose_frame(int'(frame_plan[r].len), frame_plan[r].mac, frame_plan[r].etype,
                          frame_plan[r].ihl_byte, frame_plan[r].proto, frame_plan[r].port);
            rec.verdict = frame_plan[r].verdict;
            rec.mac     = frame_plan[r].mac;
            rec.length  = (int'(frame_plan[r].len) > MAX_FRAME) ? LEN_W'(MAX_FRAME)
                                                                : frame_plan[r].len[LEN_W-1:0];
            send_frame(frame_plan[r].typed, rec);
        end

        random_base  = bytes_sent;
        verdict_base = verdicts_got;
        phase        = 0;
        more         = 1'b1;
        while (more) begin
            drain_verdicts();
            wide = {$urandom, $urandom};
            case (phase % 4)
                0: begin
                    mac_set = 48'hffff_ffff_ffff;
                    srv_set = 16'h0000;
                    cli_set = 16'hffff;
                end
                1: begin
                    mac_set = wide[MAC_W-1:0];
                    srv_set = 16'($urandom);
                    cli_set = 16'($urandom);
                end
                2: begin
                    mac_set = '0;
                    srv_set = 16'hffff;
                    cli_set = 16'h0000;
                end
                default: begin
                    mac_set = wide[MAC_W-1:0];
                    srv_set = 16'($urandom);
                    cli_set = srv_set;
                end
            endcase
            write_reg(CFG_OWN_MAC, mac_set);
            write_reg(CFG_SERVER_PORT, MAC_W'(srv_set));
            write_reg(CFG_CLIENT_PORT, MAC_W'(cli_set));
            if (phase == 0)
                write_reg(CFG_SPARE, {$urandom, $urandom});
            @(negedge aclk);
            cfg_valid <= 1'b0;
            quiet = (phase == 2);

            // starve the output so the frame queue fills and input stalls
            if (phase == 1) begin
                hold_req = 1;
                repeat (8) begin
                    frame_bytes.delete();
                    repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
                    send_frame(1'b0, no_pin);
                end
            end

            // the quiet phase runs several frames back to back
            repeat ((phase == 2) ? 3 : 1) begin
                make_random_frame();
                send_frame(1'b0, no_pin);
            end
            quiet = 1'b0;
            phase++;
            more = (bytes_sent - random_base < RANDOM_BYTES) ||
                   (verdicts_got - verdict_base < MIN_VERDICTS) || (phase < 4);
        end

        release_input();
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/eurf_pkg.sv
rtl/eurf_parser.sv
rtl/eurf_fifo.sv
rtl/eurf_judge.sv
rtl/eth_ipv4_udp_rx_filter_top.sv
tb/testbench.sv
